// ===== design/glt_pkg.sv =====
// Package for the glyph text layout block: sizes, codes and item types.
`timescale 1ns / 1ps

package glt_pkg;

    // Storage and coordinate sizes.
    localparam int TABLE_ENTRIES = 256;
    localparam int COORD_BITS    = 16;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMP_BITS      = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int EXT_BITS      = COORD_BITS + 2;

    // Item modes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_CHAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GLYPH_W     = 3'd0;
    localparam logic [2:0] CFG_GLYPH_H     = 3'd1;
    localparam logic [2:0] CFG_GLYPH_GAP   = 3'd2;
    localparam logic [2:0] CFG_BLANK_ADV   = 3'd3;
    localparam logic [2:0] CFG_LEFT_X      = 3'd4;
    localparam logic [2:0] CFG_TOP_Y       = 3'd5;
    localparam logic [2:0] CFG_RIGHT_LIMIT = 3'd6;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        ucoord_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic        entry_present;
        logic [7:0]  entry_width;
        logic [15:0] start_cursor;
    } in_item_t;

    typedef struct packed {
        logic               draw_valid;
        logic signed [15:0] draw_x;
        logic signed [15:0] draw_y;
        logic [7:0]         draw_w;
        logic [15:0]        cursor_out;
        logic signed [15:0] bound_x;
        logic signed [15:0] bound_y;
        logic [15:0]        bound_w;
        logic [15:0]        bound_h;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         glyph_w;
        logic [7:0]         glyph_h;
        logic signed [7:0]  glyph_gap;
        logic [7:0]         blank_adv;
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic signed [15:0] right_limit;
    } cfg_t;

    typedef struct packed {
        logic       present;
        logic [7:0] width;
    } glyph_t;

    // Item as it waits for the table read data.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic        in_range;
        logic [15:0] start_cursor;
        logic [15:0] col_prod;
        logic [15:0] row_prod;
    } stage_t;

endpackage

// ===== design/glyph_text_layout.sv =====
// Top level of the glyph text layout block: handshake, stages, config and checks.
`timescale 1ns / 1ps
// Path: an accepted item is registered in stage one, and its result is
// registered in the output register when stage one advances.
// Throughput: one item per cycle while the output is not stalled, set by one
// glyph table access on entry and one pen and box update per cycle in stage one.
// Reset: pen, cursor and box clear to zero, configuration takes its defaults,
// and the glyph table valid bits clear at once, so no clearing pass is needed.

module glyph_text_layout
    import glt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers. Writes to an index past the list are dropped.
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_GLYPH_W:     cfg_next.glyph_w     = cfg_data[7:0];
                CFG_GLYPH_H:     cfg_next.glyph_h     = cfg_data[7:0];
                CFG_GLYPH_GAP:   cfg_next.glyph_gap   = cfg_data[7:0];
                CFG_BLANK_ADV:   cfg_next.blank_adv   = cfg_data[7:0];
                CFG_LEFT_X:      cfg_next.left_x      = cfg_data;
                CFG_TOP_Y:       cfg_next.top_y       = cfg_data;
                CFG_RIGHT_LIMIT: cfg_next.right_limit = cfg_data;
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_w     <= 8'd8;
            cfg_reg.glyph_h     <= 8'd9;
            cfg_reg.glyph_gap   <= 8'sd0;
            cfg_reg.blank_adv   <= 8'd8;
            cfg_reg.left_x      <= 16'sd0;
            cfg_reg.top_y       <= 16'sd0;
            cfg_reg.right_limit <= 16'sd640;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake. Stage one holds an item whose table read data is now on the
    // memory output; it moves to the output register whenever that register
    // is empty or being drained, so a new item can enter every cycle while the output is not stalled.
    logic   in_accept;
    logic   out_free;
    logic   s1_adv;
    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_item_reg;
    stage_t s1_item_next;
    logic   out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    out_item_t core_result;
    glyph_t rd_entry;
    glyph_t wr_entry;
    logic   in_range;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign in_range  = (int'(in_data.char_code) < TABLE_ENTRIES);

    // The begin item's cursor scaling products are formed on entry, so stage
    // one only adds them to the text origin.
    always_comb
    begin
        s1_item_next.mode         = in_data.mode;
        s1_item_next.char_code    = in_data.char_code;
        s1_item_next.in_range     = in_range;
        s1_item_next.start_cursor = in_data.start_cursor;
        s1_item_next.col_prod     = 16'(in_data.start_cursor[7:0]) * 16'(cfg_reg.glyph_w);
        s1_item_next.row_prod     = 16'(in_data.start_cursor[15:8]) * 16'(cfg_reg.glyph_h);
    end

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (s1_adv)
        begin
            out_data_reg <= core_result;
        end
    end

    // A load writes the table at acceptance; a character item reads it at
    // acceptance, so a load followed directly by a read of the same code
    // already sees the new entry.
    assign wr_entry.present = in_data.entry_present;
    assign wr_entry.width   = in_data.entry_width;

    glt_glyph_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept && (in_data.mode == MODE_LOAD) && in_range),
        .wr_addr (in_data.char_code[TBL_AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (in_accept && (in_data.mode == MODE_CHAR)),
        .rd_addr (in_data.char_code[TBL_AW-1:0]),
        .rd_data (rd_entry)
    );

    glt_pen_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (s1_adv),
        .cfg    (cfg_reg),
        .stage  (s1_item_reg),
        .entry  (rd_entry),
        .result (core_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every accepted item occupies stage one in the following cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted item did not reach stage one");

    // Every item leaving stage one shows up as a result.
    a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("stage one advance did not produce a result");

    // A begin item reports exactly the cursor it carried.
    a_begin_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.mode == MODE_BEGIN)
        |=> out_data.cursor_out == $past(s1_item_reg.start_cursor))
        else $error("begin item cursor mismatch");

    // Results without a glyph carry an all-zero draw rectangle.
    a_nodraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.draw_valid
        |-> (out_data.draw_w == 8'd0) && (out_data.draw_x == 16'sd0)
            && (out_data.draw_y == 16'sd0))
        else $error("draw fields set on a result without a glyph");

endmodule

// ===== design/glt_glyph_ram.sv =====
// Glyph table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module glt_glyph_ram
    import glt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [TBL_AW-1:0] wr_addr,
    input  glyph_t            wr_data,
    input  logic              rd_en,
    input  logic [TBL_AW-1:0] rd_addr,
    output glyph_t            rd_data
);

    glyph_t                   mem [TABLE_ENTRIES];
    glyph_t                   rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written reads as absent with zero width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== design/glt_pen_core.sv =====
// Pen, cursor and bounding box state with the per-item update logic.
`timescale 1ns / 1ps

module glt_pen_core
    import glt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  cfg_t      cfg,
    input  stage_t    stage,
    input  glyph_t    entry,
    output out_item_t result
);

    coord_t      pen_x_reg, pen_x_next;
    coord_t      pen_y_reg, pen_y_next;
    coord_t      box_x_reg, box_x_next;
    coord_t      box_y_reg, box_y_next;
    ucoord_t     box_w_reg, box_w_next;
    ucoord_t     box_h_reg, box_h_next;
    logic [15:0] cursor_reg, cursor_next;

    always_comb
    begin
        logic                       is_nl;
        logic                       wrap;
        logic                       present;
        logic [7:0]                 gw;
        coord_t                     px;
        coord_t                     py;
        logic [15:0]                cur;
        logic signed [CMP_BITS-1:0] pen_cmp;
        logic signed [CMP_BITS-1:0] lim_cmp;
        logic signed [EXT_BITS-1:0] nw;
        logic signed [EXT_BITS-1:0] nh;
        logic                       x_lt;
        logic                       y_lt;

        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        box_x_next  = box_x_reg;
        box_y_next  = box_y_reg;
        box_w_next  = box_w_reg;
        box_h_next  = box_h_reg;
        cursor_next = cursor_reg;
        result      = '0;

        is_nl   = (stage.char_code == NEWLINE_CODE);
        pen_cmp = CMP_BITS'(pen_x_reg);
        lim_cmp = CMP_BITS'(cfg.right_limit);
        wrap    = is_nl || (pen_cmp >= lim_cmp);
        px      = wrap ? COORD_BITS'(cfg.left_x) : pen_x_reg;
        py      = wrap ? coord_t'(pen_y_reg + COORD_BITS'(cfg.glyph_h)) : pen_y_reg;
        cur     = wrap ? {cursor_reg[15:8] + 8'd1, 8'h00} : cursor_reg;
        present = stage.in_range && entry.present;
        gw      = present ? entry.width : cfg.glyph_w;
        x_lt    = (px < box_x_reg);
        y_lt    = (py < box_y_reg);
        nw      = x_lt ? EXT_BITS'(gw)
                       : EXT_BITS'(px) + EXT_BITS'(gw) - EXT_BITS'(box_x_reg);
        nh      = y_lt ? EXT_BITS'(cfg.glyph_h)
                       : EXT_BITS'(py) + EXT_BITS'(cfg.glyph_h) - EXT_BITS'(box_y_reg);

        case (stage.mode)
            MODE_BEGIN:
            begin
                cursor_next = stage.start_cursor;
                pen_x_next  = coord_t'(COORD_BITS'(stage.col_prod) + COORD_BITS'(cfg.left_x));
                pen_y_next  = coord_t'(COORD_BITS'(stage.row_prod) + COORD_BITS'(cfg.top_y));
                box_x_next  = '0;
                box_y_next  = '0;
                box_w_next  = '0;
                box_h_next  = '0;
            end
            MODE_CHAR:
            begin
                pen_x_next  = px;
                pen_y_next  = py;
                cursor_next = cur;
                if (!is_nl)
                begin
                    if (box_w_reg == '0)
                    begin
                        box_x_next = px;
                        box_y_next = py;
                        box_w_next = COORD_BITS'(gw);
                        box_h_next = COORD_BITS'(cfg.glyph_h);
                    end
                    else
                    begin
                        box_x_next = x_lt ? px : box_x_reg;
                        box_y_next = y_lt ? py : box_y_reg;
                        if (nw > $signed(EXT_BITS'(box_w_reg)))
                        begin
                            box_w_next = nw[COORD_BITS-1:0];
                        end
                        if (nh > $signed(EXT_BITS'(box_h_reg)))
                        begin
                            box_h_next = nh[COORD_BITS-1:0];
                        end
                    end
                    if (present)
                    begin
                        result.draw_valid = 1'b1;
                        result.draw_x     = 16'(px);
                        result.draw_y     = 16'(py);
                        result.draw_w     = entry.width;
                        pen_x_next = coord_t'(px + COORD_BITS'(entry.width)
                                              + COORD_BITS'(cfg.glyph_gap));
                    end
                    else
                    begin
                        pen_x_next = coord_t'(px + COORD_BITS'(cfg.blank_adv));
                    end
                    cursor_next = cur + 16'd1;
                end
            end
            default:
            begin
                // Table loads and the unused mode leave the layout state alone.
            end
        endcase

        result.cursor_out = cursor_next;
        result.bound_x    = 16'(box_x_next);
        result.bound_y    = 16'(box_y_next);
        result.bound_w    = 16'(box_w_next);
        result.bound_h    = 16'(box_h_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            box_x_reg  <= '0;
            box_y_reg  <= '0;
            box_w_reg  <= '0;
            box_h_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (adv)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            box_x_reg  <= box_x_next;
            box_y_reg  <= box_y_next;
            box_w_reg  <= box_w_next;
            box_h_reg  <= box_h_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule
